// ----- rtl/core/tqrbl_pkg.sv -----
package tqrbl_pkg;

   localparam int QUEUE_DEPTH_DEFAULT    = 16;
   localparam int BATCH_CAPACITY_DEFAULT = 10;

   localparam int ID_W        = 16;
   localparam int OP_W        = 3;
   localparam int STATUS_W    = 4;
   localparam int REQ_TDATA_W = ((ID_W + 7) / 8) * 8;

   // loading works in groups: four small slots, then one large slot
   localparam int GROUP_SIZE      = 5;
   localparam int SMALL_PER_GROUP = 4;
   localparam int POS_W           = $clog2(GROUP_SIZE);

   localparam logic [ID_W-1:0] THRESHOLD_RESET = 16'd100;

   // operation codes
   localparam logic [OP_W-1:0] OP_REGISTER  = 3'd0;
   localparam logic [OP_W-1:0] OP_ARRIVE    = 3'd1;
   localparam logic [OP_W-1:0] OP_LOAD      = 3'd2;
   localparam logic [OP_W-1:0] OP_SAIL      = 3'd3;
   localparam logic [OP_W-1:0] OP_END_CHECK = 3'd4;

   // status codes
   localparam logic [STATUS_W-1:0] ST_QUEUED        = 4'd0;
   localparam logic [STATUS_W-1:0] ST_REJECTED      = 4'd1;
   localparam logic [STATUS_W-1:0] ST_ARRIVED       = 4'd2;
   localparam logic [STATUS_W-1:0] ST_ALREADY       = 4'd3;
   localparam logic [STATUS_W-1:0] ST_NONE_WAITING  = 4'd4;
   localparam logic [STATUS_W-1:0] ST_NO_CARRIER    = 4'd5;
   localparam logic [STATUS_W-1:0] ST_PARTIAL       = 4'd6;
   localparam logic [STATUS_W-1:0] ST_MANIFEST      = 4'd7;
   localparam logic [STATUS_W-1:0] ST_NOTHING_SAIL  = 4'd8;
   localparam logic [STATUS_W-1:0] ST_STILL_WAITING = 4'd9;
   localparam logic [STATUS_W-1:0] ST_STILL_LOADED  = 4'd10;
   localparam logic [STATUS_W-1:0] ST_MAY_END       = 4'd11;

   typedef enum logic [2:0] {
      SEQ_IDLE = 3'b001,
      SEQ_LOAD = 3'b010,
      SEQ_EMIT = 3'b100
   } seq_state_type;

   typedef struct packed {
      logic push;
      logic pop;
   } fifo_ctl_type;

   typedef struct packed {
      logic empty;
      logic full;
   } fifo_stat_type;

endpackage

// ----- rtl/core/tqrbl_fifo.sv -----
module tqrbl_fifo #(
   parameter int DEPTH = tqrbl_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  tqrbl_pkg::fifo_ctl_type      ctl,
   input  logic [tqrbl_pkg::ID_W-1:0]   push_data,
   output logic [tqrbl_pkg::ID_W-1:0]   pop_data,
   output tqrbl_pkg::fifo_stat_type     stat
);

   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [tqrbl_pkg::ID_W-1:0] mem [DEPTH];
   logic [IW-1:0] head_ff, head_in;
   logic [IW-1:0] tail_ff, tail_in;
   logic [CW-1:0] count_ff, count_in;
   logic [tqrbl_pkg::ID_W-1:0] rdata_ff;

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (ctl.push) begin
         tail_in  = (tail_ff == IW'(DEPTH - 1)) ? '0 : tail_ff + IW'(1);
         count_in = count_ff + CW'(1);
      end
      if (ctl.pop) begin
         head_in  = (head_ff == IW'(DEPTH - 1)) ? '0 : head_ff + IW'(1);
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.push) begin
         mem[tail_ff] <= push_data;
      end
      if (ctl.pop) begin
         rdata_ff <= mem[head_ff];
      end
   end

   assign pop_data   = rdata_ff;
   assign stat.empty = (count_ff == '0);
   assign stat.full  = (count_ff == CW'(DEPTH));

endmodule

// ----- rtl/core/tqrbl_seq.sv -----
module tqrbl_seq #(
   parameter int BATCH_CAPACITY = tqrbl_pkg::BATCH_CAPACITY_DEFAULT,
   localparam int BCW = $clog2(BATCH_CAPACITY + 1)
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [tqrbl_pkg::ID_W-1:0]       threshold,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [tqrbl_pkg::OP_W-1:0]       req_op,
   input  logic [tqrbl_pkg::ID_W-1:0]       req_id,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [tqrbl_pkg::STATUS_W-1:0]   rsp_status,
   output logic [tqrbl_pkg::ID_W-1:0]       rsp_id,
   output logic [BCW-1:0]                   rsp_count,
   output logic                             rsp_last,
   input  tqrbl_pkg::fifo_stat_type         small_stat,
   input  tqrbl_pkg::fifo_stat_type         large_stat,
   output tqrbl_pkg::fifo_ctl_type          small_ctl,
   output tqrbl_pkg::fifo_ctl_type          large_ctl,
   input  logic [tqrbl_pkg::ID_W-1:0]       small_data,
   input  logic [tqrbl_pkg::ID_W-1:0]       large_data
);

   localparam int MIW = $clog2(BATCH_CAPACITY);

   tqrbl_pkg::seq_state_type state_ff, state_in;
   logic [BCW-1:0]                   batch_ff, batch_in;
   logic [tqrbl_pkg::POS_W-1:0]      pos_ff, pos_in;
   logic                             carrier_ff, carrier_in;
   logic [MIW-1:0]                   emit_idx_ff, emit_idx_in;
   logic                             wr_pend_ff, wr_pend_in;
   logic                             wr_small_ff, wr_small_in;
   logic [MIW-1:0]                   wr_idx_ff, wr_idx_in;
   logic [tqrbl_pkg::ID_W-1:0]       mrd_ff;
   logic [tqrbl_pkg::ID_W-1:0]       manifest [BATCH_CAPACITY];

   logic                             rsp_valid_ff, rsp_valid_in;
   logic [tqrbl_pkg::STATUS_W-1:0]   status_ff, status_in;
   logic [tqrbl_pkg::ID_W-1:0]       id_ff, id_in;
   logic [BCW-1:0]                   count_ff, count_in;
   logic                             last_ff, last_in;
   logic                             out_load;

   logic out_free;
   logic accept;
   logic both_empty;
   logic take_small;
   logic is_small;
   logic emit_last;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == tqrbl_pkg::SEQ_IDLE) && out_free;
   assign accept     = req_tvalid && req_tready;
   assign both_empty = small_stat.empty && large_stat.empty;
   assign is_small   = req_id < threshold;
   // last group slot prefers a large vehicle, the others prefer small ones
   assign take_small = (pos_ff == tqrbl_pkg::POS_W'(tqrbl_pkg::SMALL_PER_GROUP)) ?
                       large_stat.empty : !small_stat.empty;
   assign emit_last  = (BCW'(emit_idx_ff) + BCW'(1)) == batch_ff;

   always_comb begin
      state_in     = state_ff;
      batch_in     = batch_ff;
      pos_in       = pos_ff;
      carrier_in   = carrier_ff;
      emit_idx_in  = emit_idx_ff;
      wr_pend_in   = 1'b0;
      wr_small_in  = wr_small_ff;
      wr_idx_in    = wr_idx_ff;
      small_ctl    = '0;
      large_ctl    = '0;
      out_load     = 1'b0;
      status_in    = status_ff;
      id_in        = '0;
      count_in     = batch_ff;
      last_in      = 1'b1;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      unique case (state_ff)
         tqrbl_pkg::SEQ_IDLE: begin
            if (accept) begin
               unique case (req_op)
                  tqrbl_pkg::OP_REGISTER: begin
                     out_load = 1'b1;
                     if (is_small) begin
                        small_ctl.push = !small_stat.full;
                        status_in = small_stat.full ? tqrbl_pkg::ST_REJECTED
                                                    : tqrbl_pkg::ST_QUEUED;
                     end else begin
                        large_ctl.push = !large_stat.full;
                        status_in = large_stat.full ? tqrbl_pkg::ST_REJECTED
                                                    : tqrbl_pkg::ST_QUEUED;
                     end
                  end
                  tqrbl_pkg::OP_ARRIVE: begin
                     out_load = 1'b1;
                     if (carrier_ff) begin
                        status_in = tqrbl_pkg::ST_ALREADY;
                     end else begin
                        carrier_in = 1'b1;
                        batch_in   = '0;
                        pos_in     = '0;
                        count_in   = '0;
                        status_in  = tqrbl_pkg::ST_ARRIVED;
                     end
                  end
                  tqrbl_pkg::OP_LOAD: begin
                     if (both_empty) begin
                        out_load  = 1'b1;
                        status_in = tqrbl_pkg::ST_NONE_WAITING;
                     end else if (!carrier_ff) begin
                        out_load  = 1'b1;
                        status_in = tqrbl_pkg::ST_NO_CARRIER;
                     end else begin
                        state_in = tqrbl_pkg::SEQ_LOAD;
                     end
                  end
                  tqrbl_pkg::OP_SAIL: begin
                     if (batch_ff == '0 || !carrier_ff) begin
                        out_load  = 1'b1;
                        status_in = tqrbl_pkg::ST_NOTHING_SAIL;
                     end else begin
                        state_in    = tqrbl_pkg::SEQ_EMIT;
                        emit_idx_in = '0;
                     end
                  end
                  tqrbl_pkg::OP_END_CHECK: begin
                     out_load = 1'b1;
                     if (!both_empty) begin
                        status_in = tqrbl_pkg::ST_STILL_WAITING;
                     end else if (batch_ff != '0) begin
                        status_in = tqrbl_pkg::ST_STILL_LOADED;
                     end else begin
                        status_in = tqrbl_pkg::ST_MAY_END;
                        count_in  = '0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         tqrbl_pkg::SEQ_LOAD: begin
            if (batch_ff == BCW'(BATCH_CAPACITY)) begin
               state_in    = tqrbl_pkg::SEQ_EMIT;
               emit_idx_in = '0;
            end else if (both_empty) begin
               if (out_free) begin
                  out_load  = 1'b1;
                  status_in = tqrbl_pkg::ST_PARTIAL;
                  state_in  = tqrbl_pkg::SEQ_IDLE;
               end
            end else begin
               // one vehicle per cycle; the queue registers its id, which is then written into the manifest
               small_ctl.pop = take_small;
               large_ctl.pop = !take_small;
               wr_pend_in    = 1'b1;
               wr_small_in   = take_small;
               wr_idx_in     = batch_ff[MIW-1:0];
               batch_in      = batch_ff + BCW'(1);
               pos_in        = (pos_ff == tqrbl_pkg::POS_W'(tqrbl_pkg::GROUP_SIZE - 1)) ?
                               '0 : pos_ff + tqrbl_pkg::POS_W'(1);
            end
         end
         tqrbl_pkg::SEQ_EMIT: begin
            if (out_free) begin
               out_load  = 1'b1;
               status_in = tqrbl_pkg::ST_MANIFEST;
               id_in     = mrd_ff;
               count_in  = '0;
               last_in   = emit_last;
               if (emit_last) begin
                  state_in   = tqrbl_pkg::SEQ_IDLE;
                  batch_in   = '0;
                  pos_in     = '0;
                  carrier_in = 1'b0;
               end else begin
                  emit_idx_in = emit_idx_ff + MIW'(1);
               end
            end
         end
         default: begin
            state_in = tqrbl_pkg::SEQ_IDLE;
         end
      endcase

      if (out_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tqrbl_pkg::SEQ_IDLE;
         batch_ff     <= '0;
         pos_ff       <= '0;
         carrier_ff   <= 1'b0;
         emit_idx_ff  <= '0;
         wr_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         batch_ff     <= batch_in;
         pos_ff       <= pos_in;
         carrier_ff   <= carrier_in;
         emit_idx_ff  <= emit_idx_in;
         wr_pend_ff   <= wr_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      wr_small_ff <= wr_small_in;
      wr_idx_ff   <= wr_idx_in;
      if (out_load) begin
         status_ff <= status_in;
         id_ff     <= id_in;
         count_ff  <= count_in;
         last_ff   <= last_in;
      end
   end

   // manifest store: one write port from the queues, one read port for emit
   always_ff @(posedge clock) begin
      if (wr_pend_ff) begin
         manifest[wr_idx_ff] <= wr_small_ff ? small_data : large_data;
      end
      mrd_ff <= manifest[emit_idx_in];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_status = status_ff;
   assign rsp_id     = id_ff;
   assign rsp_count  = count_ff;
   assign rsp_last   = last_ff;

endmodule

// ----- rtl/core/two_queue_ratio_batch_loader_top.sv -----
// two-queue ratio batch loader
// req channel: one command per transaction, the operation in req_tuser and the
// vehicle id in req_tdata. register sorts the id into the small or large queue
// by csr threshold, arrive announces a carrier, load moves queued vehicles into
// the batch, sail ships the batch, end check reports whether work remains.
// rsp channel: status in rsp_tuser, id and batch count in rsp_tdata, rsp_tlast
// on the final result of a command. unused operation codes give no result.
// register, arrive, end check and a refused load or sail return one result.
// a load moves queued vehicles into the batch, one pop of a queue memory each
// cycle; when the batch fills, its manifest follows at one result per cycle
// while rsp_tready does not stall it. a sail emits the same way. the block
// takes no new command until every result of the current one has been handed
// to the output register; a stalled rsp_tready holds the result and stops the
// sequencer before its next result. reset empties both queues, clears batch
// and carrier and sets the threshold to 100. csr_we writes the threshold; the
// user must assert it only while idle, the block itself does not enforce this.
module two_queue_ratio_batch_loader_top #(
   parameter int QUEUE_DEPTH    = tqrbl_pkg::QUEUE_DEPTH_DEFAULT,
   parameter int BATCH_CAPACITY = tqrbl_pkg::BATCH_CAPACITY_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [tqrbl_pkg::ID_W-1:0]            csr_wdata,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [tqrbl_pkg::REQ_TDATA_W-1:0]     req_tdata,  // vehicle_id
   input  logic [tqrbl_pkg::OP_W-1:0]            req_tuser,  // operation
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // out_vehicle_id, load_count
   output logic [((tqrbl_pkg::ID_W + $clog2(BATCH_CAPACITY + 1) + 7) / 8) * 8 - 1:0]
                                                 rsp_tdata,
   output logic [tqrbl_pkg::STATUS_W-1:0]        rsp_tuser,  // status
   output logic                                  rsp_tlast   // last
);

   localparam int BCW         = $clog2(BATCH_CAPACITY + 1);
   localparam int RSP_TDATA_W = ((tqrbl_pkg::ID_W + BCW + 7) / 8) * 8;

   logic [tqrbl_pkg::ID_W-1:0] threshold_ff;
   logic [tqrbl_pkg::ID_W-1:0] req_id;
   logic [tqrbl_pkg::ID_W-1:0] small_data, large_data;
   logic [tqrbl_pkg::ID_W-1:0] rsp_id;
   logic [BCW-1:0]             rsp_count;

   tqrbl_pkg::fifo_ctl_type  small_ctl, large_ctl;
   tqrbl_pkg::fifo_stat_type small_stat, large_stat;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= tqrbl_pkg::THRESHOLD_RESET;
      end else if (csr_we) begin
         threshold_ff <= csr_wdata;
      end
   end

   assign req_id = req_tdata[tqrbl_pkg::ID_W-1:0];

   tqrbl_fifo #(.DEPTH(QUEUE_DEPTH)) u_small_queue (
      .clock     (clock),
      .reset     (reset),
      .ctl       (small_ctl),
      .push_data (req_id),
      .pop_data  (small_data),
      .stat      (small_stat)
   );

   tqrbl_fifo #(.DEPTH(QUEUE_DEPTH)) u_large_queue (
      .clock     (clock),
      .reset     (reset),
      .ctl       (large_ctl),
      .push_data (req_id),
      .pop_data  (large_data),
      .stat      (large_stat)
   );

   tqrbl_seq #(.BATCH_CAPACITY(BATCH_CAPACITY)) u_seq (
      .clock      (clock),
      .reset      (reset),
      .threshold  (threshold_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_tuser),
      .req_id     (req_id),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_status (rsp_tuser),
      .rsp_id     (rsp_id),
      .rsp_count  (rsp_count),
      .rsp_last   (rsp_tlast),
      .small_stat (small_stat),
      .large_stat (large_stat),
      .small_ctl  (small_ctl),
      .large_ctl  (large_ctl),
      .small_data (small_data),
      .large_data (large_data)
   );

   assign rsp_tdata = RSP_TDATA_W'({rsp_count, rsp_id});

   // never pop an empty queue or push a full one
   a_small_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      small_ctl.pop |-> !small_stat.empty)
      else $error("pop of empty small queue");

   a_large_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      large_ctl.pop |-> !large_stat.empty)
      else $error("pop of empty large queue");

   a_push_not_full: assert property (@(posedge clock) disable iff (reset)
      !(small_ctl.push && small_stat.full) && !(large_ctl.push && large_stat.full))
      else $error("push into full queue");

   // a push only comes from an accepted transaction, never during a load
   a_no_push_and_pop: assert property (@(posedge clock) disable iff (reset)
      (small_ctl.push || large_ctl.push) |-> !(small_ctl.pop || large_ctl.pop))
      else $error("queue push and pop in one cycle");

endmodule

// ----- tb/sv/two_queue_ratio_batch_loader_top_tb.sv -----
module two_queue_ratio_batch_loader_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ID_W            = tqrbl_pkg::ID_W;
   localparam int OP_W            = tqrbl_pkg::OP_W;
   localparam int STATUS_W        = tqrbl_pkg::STATUS_W;
   localparam int REQ_TDATA_W     = tqrbl_pkg::REQ_TDATA_W;
   localparam int GROUP_SIZE      = tqrbl_pkg::GROUP_SIZE;
   localparam int SMALL_PER_GROUP = tqrbl_pkg::SMALL_PER_GROUP;
   localparam int Q_DEPTH         = tqrbl_pkg::QUEUE_DEPTH_DEFAULT;
   localparam int CAP             = tqrbl_pkg::BATCH_CAPACITY_DEFAULT;
   localparam int CNT_W           = $clog2(CAP + 1);
   localparam int RSP_TDATA_W     = ((ID_W + CNT_W + 7) / 8) * 8;
   localparam int SETTLE_CYCLES   = 2 * CAP + 4;
   localparam int CYCLE_LIMIT     = 400000;
   localparam int RANDOM_ITEMS    = 340;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ID_W-1:0]     vid;
      logic [CNT_W-1:0]    count;
      logic                last;
   } loader_rsp_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_we;
   logic [ID_W-1:0]        csr_wdata;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic [OP_W-1:0]        req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [STATUS_W-1:0]    rsp_tuser;
   logic                   rsp_tlast;

   // loader state as predicted
   logic [ID_W-1:0] short_mem [Q_DEPTH];
   logic [ID_W-1:0] long_mem [Q_DEPTH];
   logic [ID_W-1:0] batch_ids [CAP];
   int              short_cnt, short_head, short_tail;
   int              long_cnt, long_head, long_tail;
   int              batch_n;
   logic            carrier_here;
   logic [ID_W-1:0] threshold;

   loader_rsp_type pending_rsp [$];
   int             mismatches;
   int             cycles;
   int             items_sent;
   bit             idle_on;

   two_queue_ratio_batch_loader_top #(
      .QUEUE_DEPTH   (Q_DEPTH),
      .BATCH_CAPACITY(CAP)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("[two_queue_ratio_batch_loader_top] ERROR");
         $finish;
      end
   end

   // ---------------- predictor ----------------

   task automatic expect_rsp(input logic [STATUS_W-1:0] st, input logic [ID_W-1:0] vid,
                             input int cnt, input logic last);
      loader_rsp_type r;
      r.status = st;
      r.vid    = vid;
      r.count  = cnt[CNT_W-1:0];
      r.last   = last;
      pending_rsp.push_back(r);
   endtask

   task automatic take_vehicle(input bit from_short);
      if (from_short) begin
         batch_ids[batch_n] = short_mem[short_head];
         short_head = (short_head + 1) % Q_DEPTH;
         short_cnt--;
      end else begin
         batch_ids[batch_n] = long_mem[long_head];
         long_head = (long_head + 1) % Q_DEPTH;
         long_cnt--;
      end
      batch_n++;
   endtask

   task automatic ship_batch();
      for (int k = 0; k < batch_n; k++)
         expect_rsp(tqrbl_pkg::ST_MANIFEST, batch_ids[k], 0, k == batch_n - 1);
      batch_n      = 0;
      carrier_here = 1'b0;
   endtask

   task automatic load_batch();
      int pos;
      bit shipped;
      shipped = 1'b0;
      if (short_cnt == 0 && long_cnt == 0) begin
         expect_rsp(tqrbl_pkg::ST_NONE_WAITING, '0, batch_n, 1'b1);
      end else if (!carrier_here) begin
         expect_rsp(tqrbl_pkg::ST_NO_CARRIER, '0, batch_n, 1'b1);
      end else begin
         while (!shipped && (short_cnt != 0 || long_cnt != 0)) begin
            pos = batch_n % GROUP_SIZE;
            while (short_cnt != 0 && batch_n < CAP && pos < SMALL_PER_GROUP) begin
               take_vehicle(1'b1);
               pos++;
            end
            if (batch_n < CAP) begin
               if (pos == SMALL_PER_GROUP) begin
                  // large slot, taken by a small vehicle when no large one waits
                  if (long_cnt != 0)
                     take_vehicle(1'b0);
                  else if (short_cnt != 0)
                     take_vehicle(1'b1);
               end else begin
                  while (long_cnt != 0 && batch_n < CAP && pos < GROUP_SIZE) begin
                     take_vehicle(1'b0);
                     pos++;
                  end
               end
            end
            if (batch_n >= CAP) begin
               ship_batch();
               shipped = 1'b1;
            end
         end
         if (!shipped)
            expect_rsp(tqrbl_pkg::ST_PARTIAL, '0, batch_n, 1'b1);
      end
   endtask

   task automatic loader_predict(input logic [OP_W-1:0] op, input logic [ID_W-1:0] vid);
      bit ok;
      case (op)
         tqrbl_pkg::OP_REGISTER: begin
            ok = 1'b0;
            if (vid < threshold) begin
               if (short_cnt < Q_DEPTH) begin
                  short_mem[short_tail] = vid;
                  short_tail = (short_tail + 1) % Q_DEPTH;
                  short_cnt++;
                  ok = 1'b1;
               end
            end else if (long_cnt < Q_DEPTH) begin
               long_mem[long_tail] = vid;
               long_tail = (long_tail + 1) % Q_DEPTH;
               long_cnt++;
               ok = 1'b1;
            end
            expect_rsp(ok ? tqrbl_pkg::ST_QUEUED : tqrbl_pkg::ST_REJECTED, '0, batch_n, 1'b1);
         end
         tqrbl_pkg::OP_ARRIVE: begin
            if (carrier_here) begin
               expect_rsp(tqrbl_pkg::ST_ALREADY, '0, batch_n, 1'b1);
            end else begin
               carrier_here = 1'b1;
               batch_n      = 0;
               expect_rsp(tqrbl_pkg::ST_ARRIVED, '0, 0, 1'b1);
            end
         end
         tqrbl_pkg::OP_LOAD: load_batch();
         tqrbl_pkg::OP_SAIL: begin
            if (batch_n == 0 || !carrier_here)
               expect_rsp(tqrbl_pkg::ST_NOTHING_SAIL, '0, batch_n, 1'b1);
            else
               ship_batch();
         end
         tqrbl_pkg::OP_END_CHECK: begin
            if (short_cnt != 0 || long_cnt != 0)
               expect_rsp(tqrbl_pkg::ST_STILL_WAITING, '0, batch_n, 1'b1);
            else if (batch_n != 0)
               expect_rsp(tqrbl_pkg::ST_STILL_LOADED, '0, batch_n, 1'b1);
            else
               expect_rsp(tqrbl_pkg::ST_MAY_END, '0, 0, 1'b1);
         end
         default: ;  // unused codes give no result
      endcase
   endtask

   // ---------------- response checking ----------------

   always @(posedge clock) begin : check_rsp
      loader_rsp_type         want;
      logic [RSP_TDATA_W-1:0] want_tdata;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: status %0d tdata %h last %b",
                        rsp_tuser, rsp_tdata, rsp_tlast);
         end else begin
            want       = pending_rsp.pop_front();
            want_tdata = RSP_TDATA_W'({want.count, want.vid});
            if (rsp_tuser !== want.status || rsp_tdata !== want_tdata ||
                rsp_tlast !== want.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"mismatch: expected status %0d id %0d count %0d last %b, ",
                            "got status %0d id %0d count %0d last %b (tdata %h)"},
                           want.status, want.vid, want.count, want.last,
                           rsp_tuser, rsp_tdata[ID_W-1:0], rsp_tdata[ID_W +: CNT_W],
                           rsp_tlast, rsp_tdata);
            end
         end
      end
   end

   // result-side back-pressure in random bursts
   always begin
      rsp_tready = 1'b1;
      @(negedge clock);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         rsp_tready = 1'b0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
   end

   // ---------------- stimulus helpers ----------------

   // called at a falling edge, returns at a falling edge
   task automatic send_cmd(input logic [OP_W-1:0] op, input logic [ID_W-1:0] vid);
      if (idle_on && $urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 13)) @(negedge clock);
      req_tvalid = 1'b1;
      req_tuser  = op;
      req_tdata  = vid;
      do @(posedge clock); while (!req_tready);
      loader_predict(op, vid);
      if (op <= tqrbl_pkg::OP_END_CHECK)
         items_sent++;
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   task automatic wait_idle();
      while (pending_rsp.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_threshold(input logic [ID_W-1:0] value);
      wait_idle();
      csr_we    = 1'b1;
      csr_wdata = value;
      @(negedge clock);
      csr_we    = 1'b0;
      threshold = value;
   endtask

   function automatic logic [ID_W-1:0] pick_vid();
      int t;
      t = threshold;
      case ($urandom_range(0, 3))
         0: return (t == 0) ? ID_W'($urandom) : ID_W'($urandom_range(0, t - 1));
         1: return ID_W'($urandom_range((t > 0) ? t - 1 : 0, (t < 65535) ? t + 1 : 65535));
         default: return ID_W'($urandom);
      endcase
   endfunction

   task automatic run_batch_sequence();
      repeat ($urandom_range(0, 14)) send_cmd(tqrbl_pkg::OP_REGISTER, pick_vid());
      if ($urandom_range(0, 4) != 0)
         send_cmd(tqrbl_pkg::OP_ARRIVE, ID_W'($urandom));
      repeat ($urandom_range(1, 2)) send_cmd(tqrbl_pkg::OP_LOAD, ID_W'($urandom));
      if ($urandom_range(0, 2) != 0)
         send_cmd(tqrbl_pkg::OP_SAIL, ID_W'($urandom));
      if ($urandom_range(0, 3) == 0)
         send_cmd(tqrbl_pkg::OP_END_CHECK, ID_W'($urandom));
   endtask

   // ---------------- tests ----------------

   task automatic test_directed_ops();
      send_cmd(tqrbl_pkg::OP_END_CHECK, '0);
      send_cmd(tqrbl_pkg::OP_LOAD, '0);             // both queues empty
      send_cmd(tqrbl_pkg::OP_SAIL, '0);             // no carrier
      send_cmd(tqrbl_pkg::OP_ARRIVE, '0);
      send_cmd(tqrbl_pkg::OP_SAIL, '0);             // carrier but empty batch
      send_cmd(tqrbl_pkg::OP_ARRIVE, '0);           // already present
      send_cmd(tqrbl_pkg::OP_REGISTER, 16'd0);
      send_cmd(tqrbl_pkg::OP_REGISTER, 16'd99);
      send_cmd(tqrbl_pkg::OP_REGISTER, 16'd100);
      send_cmd(tqrbl_pkg::OP_REGISTER, 16'hFFFF);
      send_cmd(tqrbl_pkg::OP_END_CHECK, '0);
      send_cmd(tqrbl_pkg::OP_LOAD, '0);
      send_cmd(tqrbl_pkg::OP_END_CHECK, '0);        // batch still loaded
      send_cmd(3'd5, 16'h1234);
      send_cmd(3'd6, 16'hFFFF);
      send_cmd(3'd7, 16'h0000);
      send_cmd(tqrbl_pkg::OP_SAIL, '0);
      send_cmd(tqrbl_pkg::OP_REGISTER, 16'd5);
      send_cmd(tqrbl_pkg::OP_LOAD, '0);             // vehicles wait, no carrier
      send_cmd(tqrbl_pkg::OP_END_CHECK, '0);
   endtask

   task automatic test_queue_overflow();
      repeat (Q_DEPTH + 1)
         send_cmd(tqrbl_pkg::OP_REGISTER, ID_W'($urandom_range(0, 99)));
      repeat (Q_DEPTH + 1)
         send_cmd(tqrbl_pkg::OP_REGISTER, ID_W'($urandom_range(100, 65535)));
      repeat (4) begin
         send_cmd(tqrbl_pkg::OP_ARRIVE, '0);
         send_cmd(tqrbl_pkg::OP_LOAD, '0);
      end
      send_cmd(tqrbl_pkg::OP_SAIL, '0);
      send_cmd(tqrbl_pkg::OP_END_CHECK, '0);
   endtask

   task automatic test_short_fills_long_slot();
      repeat (12) send_cmd(tqrbl_pkg::OP_REGISTER, ID_W'($urandom_range(0, 99)));
      send_cmd(tqrbl_pkg::OP_ARRIVE, '0);
      send_cmd(tqrbl_pkg::OP_LOAD, '0);
      send_cmd(tqrbl_pkg::OP_ARRIVE, '0);
      send_cmd(tqrbl_pkg::OP_LOAD, '0);
      send_cmd(tqrbl_pkg::OP_SAIL, '0);
      send_cmd(tqrbl_pkg::OP_END_CHECK, '0);
   endtask

   task automatic test_threshold_extremes();
      set_threshold(16'd0);              // everything is large
      repeat (3) send_cmd(tqrbl_pkg::OP_REGISTER, ID_W'($urandom));
      send_cmd(tqrbl_pkg::OP_REGISTER, 16'd0);
      set_threshold(16'hFFFF);
      send_cmd(tqrbl_pkg::OP_REGISTER, 16'hFFFF);
      send_cmd(tqrbl_pkg::OP_REGISTER, 16'hFFFE);
      set_threshold(16'd1);
      send_cmd(tqrbl_pkg::OP_REGISTER, 16'd0);
      send_cmd(tqrbl_pkg::OP_REGISTER, 16'd1);
      send_cmd(tqrbl_pkg::OP_ARRIVE, '0);
      send_cmd(tqrbl_pkg::OP_LOAD, '0);
      send_cmd(tqrbl_pkg::OP_SAIL, '0);
      send_cmd(tqrbl_pkg::OP_END_CHECK, '0);
   endtask

   task automatic test_random_traffic();
      int goal;
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: set_threshold(ID_W'($urandom));
            1: set_threshold(tqrbl_pkg::THRESHOLD_RESET);
            2: set_threshold(ID_W'($urandom_range(20, 40000)));
            default: begin
               set_threshold(ID_W'($urandom));
               idle_on = 1'b0;
            end
         endcase
         goal = items_sent + RANDOM_ITEMS / 4;
         while (items_sent < goal) begin
            if ($urandom_range(0, 4) != 0)
               run_batch_sequence();
            else
               send_cmd(OP_W'($urandom_range(0, 7)), ID_W'($urandom));
         end
      end
   endtask

   initial begin
      reset        = 1'b1;
      csr_we       = 1'b0;
      csr_wdata    = '0;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = '0;
      idle_on      = 1'b1;
      mismatches   = 0;
      cycles       = 0;
      items_sent   = 0;
      short_cnt    = 0;
      short_head   = 0;
      short_tail   = 0;
      long_cnt     = 0;
      long_head    = 0;
      long_tail    = 0;
      batch_n      = 0;
      carrier_here = 1'b0;
      threshold    = tqrbl_pkg::THRESHOLD_RESET;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_ops();
      test_queue_overflow();
      test_short_fills_long_slot();
      test_threshold_extremes();
      test_random_traffic();

      wait_idle();
      if (mismatches == 0) begin
         $display("[two_queue_ratio_batch_loader_top] OK");
      end else begin
         $display("[two_queue_ratio_batch_loader_top] ERROR");
      end
      $finish;
   end

endmodule
